// ----- hw/rtl/uvs_pkg.sv -----
// ----------------------------------------------------------------------------
// uvs_pkg: shared types and constants for the UV-sphere vertex generator
// Holds the pipeline item, the stage map, register indexes and CORDIC table.
// ----------------------------------------------------------------------------
package uvs_pkg;

  // Register indexes on the configuration port (word address)
  localparam logic [1:0] REG_RADIUS  = 2'd0;
  localparam logic [1:0] REG_SECTORS = 2'd1;
  localparam logic [1:0] REG_STACKS  = 2'd2;

  // Register reset values
  localparam logic [15:0] RADIUS_RESET  = 16'd256;
  localparam logic [8:0]  SECTORS_RESET = 9'd36;
  localparam logic [7:0]  STACKS_RESET  = 8'd18;

  // Largest usable counts; the port and register widths are sized for these
  localparam int MAX_SECTORS = 256;
  localparam int MAX_STACKS  = 128;

  // Stage map of the pipeline
  localparam int DIV_STEPS    = 3;   // divider steps per stage
  localparam int DIV_LAST     = 7;
  localparam int ANG_STAGE    = 8;
  localparam int CORDIC_FIRST = 9;
  localparam int CORDIC_STEPS = 2;   // rotations per stage
  localparam int CORDIC_LAST  = 16;
  localparam int MUL_STAGE    = 17;
  localparam int NORM_STAGE   = 18;
  localparam int RAD_STAGE    = 19;
  localparam int POS_STAGE    = 20;
  localparam int NUM_STAGES   = 21;

  // CORDIC constants: gain in Q29, arctangents in 2^20 units per turn
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd326016437;
  localparam logic signed [21:0] ATAN_TURNS [16] = '{
    22'sd131072, 22'sd77376, 22'sd40884, 22'sd20753, 22'sd10417, 22'sd5213,
    22'sd2607, 22'sd1304, 22'sd652, 22'sd326, 22'sd163, 22'sd81, 22'sd41,
    22'sd20, 22'sd10, 22'sd5
  };

  // One item as it travels the pipeline
  typedef struct packed {
    logic               err;
    logic [7:0]         i;
    logic [8:0]         j;
    logic [21:0]        qs;
    logic [8:0]         rs;
    logic [21:0]        qt;
    logic [7:0]         rt;
    logic [16:0]        tex_s;
    logic [16:0]        tex_t;
    logic [15:0]        vnum;
    logic               up;
    logic               lo;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic signed [21:0] a1;
    logic               neg1;
    logic signed [31:0] x2;
    logic signed [31:0] y2;
    logic signed [21:0] a2;
    logic               neg2;
    logic signed [63:0] p0;
    logic signed [63:0] p2;
    logic signed [31:0] nq0;
    logic signed [31:0] nq1;
    logic signed [31:0] nq2;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic signed [48:0] r0;
    logic signed [48:0] r1;
    logic signed [48:0] r2;
    logic signed [16:0] px;
    logic signed [16:0] py;
    logic signed [16:0] pz;
  } item_t;

  // Wrap an angle to a signed value and fold it into a quarter turn either way.
  // Bit 22 flags a fold (both results negate), bits 21:0 hold the angle.
  function automatic logic [22:0] fold_angle(input logic [19:0] ang);
    logic signed [21:0] a;
    logic               neg;
    a   = 22'($signed(ang));
    neg = 1'b0;
    if (a > 22'sd262144) begin
      a   = a - 22'sd524288;
      neg = 1'b1;
    end else if (a < -22'sd262144) begin
      a   = a + 22'sd524288;
      neg = 1'b1;
    end
    return {neg, a};
  endfunction

  // Round Q29 to Q14 half up and saturate to one
  function automatic logic signed [15:0] sat_norm(input logic signed [31:0] v);
    logic signed [32:0] t;
    t = ($signed({v[31], v}) + 33'sd16384) >>> 15;
    if (t > 33'sd16384) begin
      t = 33'sd16384;
    end else if (t < -33'sd16384) begin
      t = -33'sd16384;
    end
    return t[15:0];
  endfunction

  // Round radius times Q29 normal to Q8.8 half up and saturate
  function automatic logic signed [16:0] sat_pos(input logic signed [48:0] v);
    logic signed [48:0] t;
    t = (v + 49'sd268435456) >>> 29;
    if (t > 49'sd65535) begin
      t = 49'sd65535;
    end else if (t < -49'sd65535) begin
      t = -49'sd65535;
    end
    return t[16:0];
  endfunction

endpackage

// ----- hw/rtl/uv_sphere_vertex_generator.sv -----
// ----------------------------------------------------------------------------
// Throughput: one item per cycle unless vertex_stall holds the output; the 21-stage pipeline advances stage by stage,
// a stage loading whenever it is empty or the stage after it moves on.
// Reset (rst, synchronous): pipeline emptied, radius 256, 36 sectors, 18 stacks.
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator: UV-sphere vertex from a grid point
// Divides the indices by the counts, runs two CORDICs for the angles, then
// multiplies out normal and position.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator
  import uvs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [7:0]         stack_index,
  input  logic [8:0]         sector_index,
  output logic               vertex_valid,
  input  logic               vertex_stall,
  output logic signed [16:0] pos_x,
  output logic signed [16:0] pos_y,
  output logic signed [16:0] pos_z,
  output logic signed [15:0] norm_x,
  output logic signed [15:0] norm_y,
  output logic signed [15:0] norm_z,
  output logic [16:0]        tex_s,
  output logic [16:0]        tex_t,
  output logic [15:0]        vertex_number,
  output logic               upper_tri_valid,
  output logic               lower_tri_valid,
  output logic               index_error
);

  logic [15:0] sphere_radius;
  logic [8:0]  sector_count;
  logic [7:0]  stack_count;
  logic [8:0]  ns;
  logic [7:0]  nt;

  item_t                 pipe [NUM_STAGES];
  item_t                 nxt  [NUM_STAGES];
  item_t                 in_item;
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES:0]   go;
  logic                  out_err;

  // One pipeline stage of work, chosen by stage number
  function automatic item_t stage_step(input int k, input item_t d, input logic [8:0] cs_n,
                                       input logic [7:0] ct_n, input logic [15:0] rad);
    item_t              r;
    logic [9:0]         rs2;
    logic [8:0]         rt2;
    logic               bs;
    logic               bt;
    logic [21:0]        sq;
    logic [20:0]        tq;
    logic [17:0]        tx;
    logic [17:0]        vn;
    logic [19:0]        stk;
    logic [22:0]        f;
    logic signed [31:0] nxv;
    logic signed [31:0] c1;
    logic signed [31:0] s1;
    logic signed [31:0] c2;
    logic signed [31:0] s2;
    int                 kk;
    r = d;
    if (k == 0) begin
      // first quotient bit: the index never exceeds its count when in range
      r.err = (d.i > ct_n) || (d.j > cs_n);
      r.qs  = {21'd0, d.j == cs_n};
      r.rs  = (d.j == cs_n) ? 9'd0 : d.j;
      r.qt  = {21'd0, d.i == ct_n};
      r.rt  = (d.i == ct_n) ? 8'd0 : d.i;
    end else if (k <= DIV_LAST) begin
      // restoring division, one quotient bit per step
      for (int n = 0; n < DIV_STEPS; n++) begin
        rs2 = {r.rs, 1'b0};
        bs  = (rs2 >= {1'b0, cs_n});
        if (bs) begin
          rs2 = rs2 - {1'b0, cs_n};
        end
        r.rs = rs2[8:0];
        r.qs = {r.qs[20:0], bs};
        rt2  = {r.rt, 1'b0};
        bt   = (rt2 >= {1'b0, ct_n});
        if (bt) begin
          rt2 = rt2 - {1'b0, ct_n};
        end
        r.rt = rt2[7:0];
        r.qt = {r.qt[20:0], bt};
      end
    end else if (k == ANG_STAGE) begin
      // quotients hold index * 2^21 / count; round down to each use
      sq      = (r.qs + 22'd1) >> 1;
      tq      = (21'(r.qt >> 1) + 21'd1) >> 1;
      stk     = 20'h40000 - tq[19:0];
      tx      = (18'(r.qs >> 4) + 18'd1) >> 1;
      r.tex_s = tx[16:0];
      tx      = (18'(r.qt >> 4) + 18'd1) >> 1;
      r.tex_t = tx[16:0];
      vn      = 18'(d.i) * 18'({1'b0, cs_n} + 10'd1) + 18'(d.j);
      r.vnum  = vn[15:0];
      if ((d.i < ct_n) && (d.j < cs_n)) begin
        r.up = (d.i != 8'd0);
        r.lo = (d.i != (ct_n - 8'd1));
      end else begin
        r.up = 1'b0;
        r.lo = 1'b0;
      end
      f      = fold_angle(stk);
      r.neg1 = f[22];
      r.a1   = $signed(f[21:0]);
      f      = fold_angle(sq[19:0]);
      r.neg2 = f[22];
      r.a2   = $signed(f[21:0]);
      r.x1   = CORDIC_GAIN;
      r.y1   = 32'sd0;
      r.x2   = CORDIC_GAIN;
      r.y2   = 32'sd0;
    end else if (k <= CORDIC_LAST) begin
      // rotate both vectors towards their angles
      for (int n = 0; n < CORDIC_STEPS; n++) begin
        kk = CORDIC_STEPS * (k - CORDIC_FIRST) + n;
        if (r.a1 >= 22'sd0) begin
          nxv  = r.x1 - (r.y1 >>> kk);
          r.y1 = r.y1 + (r.x1 >>> kk);
          r.a1 = r.a1 - ATAN_TURNS[kk];
        end else begin
          nxv  = r.x1 + (r.y1 >>> kk);
          r.y1 = r.y1 - (r.x1 >>> kk);
          r.a1 = r.a1 + ATAN_TURNS[kk];
        end
        r.x1 = nxv;
        if (r.a2 >= 22'sd0) begin
          nxv  = r.x2 - (r.y2 >>> kk);
          r.y2 = r.y2 + (r.x2 >>> kk);
          r.a2 = r.a2 - ATAN_TURNS[kk];
        end else begin
          nxv  = r.x2 + (r.y2 >>> kk);
          r.y2 = r.y2 - (r.x2 >>> kk);
          r.a2 = r.a2 + ATAN_TURNS[kk];
        end
        r.x2 = nxv;
      end
    end else if (k == MUL_STAGE) begin
      // undo the fold and form the horizontal components
      c1    = d.neg1 ? -d.x1 : d.x1;
      s1    = d.neg1 ? -d.y1 : d.y1;
      c2    = d.neg2 ? -d.x2 : d.x2;
      s2    = d.neg2 ? -d.y2 : d.y2;
      r.p0  = c1 * c2;
      r.p2  = c1 * s2;
      r.nq1 = s1;
    end else if (k == NORM_STAGE) begin
      r.nq0 = 32'((d.p0 + 64'sd268435456) >>> 29);
      r.nq2 = 32'((d.p2 + 64'sd268435456) >>> 29);
      r.nx  = sat_norm(32'((d.p0 + 64'sd268435456) >>> 29));
      r.ny  = sat_norm(d.nq1);
      r.nz  = sat_norm(32'((d.p2 + 64'sd268435456) >>> 29));
    end else if (k == RAD_STAGE) begin
      r.r0 = $signed({1'b0, rad}) * d.nq0;
      r.r1 = $signed({1'b0, rad}) * d.nq1;
      r.r2 = $signed({1'b0, rad}) * d.nq2;
    end else begin
      r.px = sat_pos(d.r0);
      r.py = sat_pos(d.r1);
      r.pz = sat_pos(d.r2);
    end
    return r;
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius <= RADIUS_RESET;
      sector_count  <= SECTORS_RESET;
      stack_count   <= STACKS_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_RADIUS:  sphere_radius <= pwdata[15:0];
        REG_SECTORS: sector_count  <= pwdata[8:0];
        REG_STACKS:  stack_count   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (paddr[3:2])
      REG_RADIUS:  prdata = {16'd0, sphere_radius};
      REG_SECTORS: prdata = {23'd0, sector_count};
      REG_STACKS:  prdata = {24'd0, stack_count};
      default:     prdata = 32'd0;
    endcase
  end

  assign pready = 1'b1;

  // Clamp the counts to their usable range
  always_comb begin
    ns = sector_count;
    if (sector_count < 9'd3) begin
      ns = 9'd3;
    end else if (32'(sector_count) > MAX_SECTORS) begin
      ns = 9'(MAX_SECTORS);
    end
    nt = stack_count;
    if (stack_count < 8'd2) begin
      nt = 8'd2;
    end else if (32'(stack_count) > MAX_STACKS) begin
      nt = 8'(MAX_STACKS);
    end
  end

  // Stage logic
  always_comb begin
    in_item   = '0;
    in_item.i = stack_index;
    in_item.j = sector_index;
    nxt[0]    = stage_step(0, in_item, ns, nt, sphere_radius);
    for (int k = 1; k < NUM_STAGES; k++) begin
      nxt[k] = stage_step(k, pipe[k-1], ns, nt, sphere_radius);
    end
  end

  // Advance a stage when it is empty or the next one moves on
  always_comb begin
    go[NUM_STAGES] = !vertex_stall;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      go[k] = !vld[k] || go[k+1];
    end
  end

  assign item_stall = !go[0];

  // Pipeline registers, valid bits travel with the item
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (go[0]) begin
        vld[0] <= item_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (go[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (go[k]) begin
        pipe[k] <= nxt[k];
      end
    end
  end

  // Outputs: an index error zeroes every field but the flag
  assign out_err         = pipe[POS_STAGE].err;
  assign vertex_valid    = vld[POS_STAGE];
  assign index_error     = out_err;
  assign pos_x           = out_err ? 17'sd0 : pipe[POS_STAGE].px;
  assign pos_y           = out_err ? 17'sd0 : pipe[POS_STAGE].py;
  assign pos_z           = out_err ? 17'sd0 : pipe[POS_STAGE].pz;
  assign norm_x          = out_err ? 16'sd0 : pipe[POS_STAGE].nx;
  assign norm_y          = out_err ? 16'sd0 : pipe[POS_STAGE].ny;
  assign norm_z          = out_err ? 16'sd0 : pipe[POS_STAGE].nz;
  assign tex_s           = out_err ? 17'd0 : pipe[POS_STAGE].tex_s;
  assign tex_t           = out_err ? 17'd0 : pipe[POS_STAGE].tex_t;
  assign vertex_number   = out_err ? 16'd0 : pipe[POS_STAGE].vnum;
  assign upper_tri_valid = !out_err && pipe[POS_STAGE].up;
  assign lower_tri_valid = !out_err && pipe[POS_STAGE].lo;

endmodule

// ----- verif/uv_sphere_vertex_generator_tb.sv -----
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_tb: self-checking bench for the UV-sphere block
// Sends grid points through the valid/stall channel under several register
// settings. Each vertex is compared field by field with an in-bench fixed-point
// predictor (CORDIC, rounding, saturation). The sender idles and the receiver stalls at random.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator_tb;
  import uvs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [16:0] px, py, pz;
    logic signed [15:0] nx, ny, nz;
    logic [16:0]        ts, tt;
    logic [15:0]        vnum;
    logic               up, lo, err;
  } vertex_t;

  typedef struct {
    int unsigned i;
    int unsigned j;
    bit          is_error;
  } grid_row_t;

  typedef struct {
    int unsigned radius, sectors, stacks, count;
    bit          calm, hold;
  } phase_t;

  localparam longint ARCTAN [16] = '{131072, 77376, 40884, 20753, 10417, 5213, 2607,
                                     1304, 652, 326, 163, 81, 41, 20, 10, 5};
  localparam longint GAIN_Q29 = 326016437;
  localparam int TAIL_CYCLES = 40;
  localparam int HOLD_CYCLES = 200;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic item_valid, item_stall;
  logic [7:0] stack_index;
  logic [8:0] sector_index;
  logic vertex_valid, vertex_stall;
  logic signed [16:0] pos_x, pos_y, pos_z;
  logic signed [15:0] norm_x, norm_y, norm_z;
  logic [16:0] tex_s, tex_t;
  logic [15:0] vertex_number;
  logic upper_tri_valid, lower_tri_valid, index_error;

  // shadow registers used by the predictor
  longint radius_q, sectors_q, stacks_q;

  vertex_t pending_vertices[$];
  int      fail_count = 0;
  bit      calm;
  int      hold_cycles = 0;
  int      hold_asked = 0;
  int      hold_done = 0;

  uv_sphere_vertex_generator dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hang guard
  initial begin
    #2_000_000;
    $display("uv_sphere_vertex_generator_tb failed");
    $finish;
  end

  // rotation-mode CORDIC, 2^20 units per turn, results in Q29
  function automatic void cordic_sincos(input longint ang, output longint s,
                                        output longint c);
    longint a, x, y, nx;
    bit neg;
    a = ang & 64'hFFFFF;
    neg = 1'b0;
    x = GAIN_Q29;
    y = 0;
    if (a >= 524288) a -= 1048576;
    if (a > 262144) begin
      a -= 524288;
      neg = 1'b1;
    end else if (a < -262144) begin
      a += 524288;
      neg = 1'b1;
    end
    for (int k = 0; k < 16; k++) begin
      if (a >= 0) begin
        nx = x - (y >>> k);
        y  = y + (x >>> k);
        a -= ARCTAN[k];
      end else begin
        nx = x + (y >>> k);
        y  = y - (x >>> k);
        a += ARCTAN[k];
      end
      x = nx;
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic longint div_round(longint num, longint den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic longint round_down(longint v, int k);
    return (v + (longint'(1) << (k - 1))) >>> k;
  endfunction

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // expected vertex for grid point (i, j) under the current registers
  function automatic vertex_t sphere_vertex(longint i, longint j);
    vertex_t v;
    longint ns, nt, ss, cs, st, ct, r;
    longint nq [3];
    longint pq [3];
    longint nn [3];
    v = '{default: '0};
    ns = (sectors_q < 3) ? 3 : (sectors_q > 256) ? 256 : sectors_q;
    nt = (stacks_q < 2) ? 2 : (stacks_q > 128) ? 128 : stacks_q;
    r = radius_q;
    if (i > nt || j > ns) begin
      v.err = 1'b1;
      return v;
    end
    cordic_sincos(262144 - div_round(i << 19, nt), ss, cs);
    cordic_sincos(div_round(j << 20, ns), st, ct);
    nq[0] = round_down(cs * ct, 29);
    nq[1] = ss;
    nq[2] = round_down(cs * st, 29);
    for (int f = 0; f < 3; f++) begin
      pq[f] = clip(round_down(r * nq[f], 29), 65535);
      nn[f] = clip(round_down(nq[f], 15), 16384);
    end
    v.px = 17'(pq[0]); v.py = 17'(pq[1]); v.pz = 17'(pq[2]);
    v.nx = 16'(nn[0]); v.ny = 16'(nn[1]); v.nz = 16'(nn[2]);
    v.ts = 17'(div_round(j << 16, ns));
    v.tt = 17'(div_round(i << 16, nt));
    v.vnum = 16'(i * (ns + 1) + j);
    if (i < nt && j < ns) begin
      v.up = (i != 0);
      v.lo = (i != nt - 1);
    end
    return v;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch %s: got %0d, want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic check_field(string what, longint got, longint want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // register write: setup cycle, then access cycle
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_RADIUS:  radius_q  = value & 32'hFFFF;
      REG_SECTORS: sectors_q = value & 32'h1FF;
      REG_STACKS:  stacks_q  = value & 32'hFF;
      default: ;
    endcase
  endtask

  // offer one grid point and hold it until accepted
  task automatic send_point(int unsigned i, int unsigned j, bit typed_error);
    vertex_t want;
    if (!calm && $urandom_range(99) < 34) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    if (typed_error) begin
      want = '{default: '0};
      want.err = 1'b1;
    end else begin
      want = sphere_vertex(i, j);
    end
    item_valid <= 1'b1;
    stack_index <= 8'(i);
    sector_index <= 9'(j);
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pending_vertices.insert(pending_vertices.size(), want);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // receiver side: random stalls, a long hold-off when one is asked for
  always @(posedge clk) begin
    if (hold_done != hold_asked) begin
      vertex_stall <= 1'b1;
      hold_cycles <= HOLD_CYCLES;
      hold_done <= hold_asked;
    end else if (hold_cycles > 0) begin
      vertex_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (calm) begin
      vertex_stall <= 1'b0;
    end else begin
      vertex_stall <= ($urandom_range(99) < 34);
    end
  end

  // compare each accepted vertex with the oldest expectation
  always @(posedge clk) begin
    vertex_t want;
    if (!rst && vertex_valid && !vertex_stall) begin
      if (pending_vertices.size() == 0) begin
        report_mismatch("unexpected vertex", vertex_number, -1);
      end else begin
        want = pending_vertices.pop_front();
        check_field("pos_x", pos_x, want.px);
        check_field("pos_y", pos_y, want.py);
        check_field("pos_z", pos_z, want.pz);
        check_field("norm_x", norm_x, want.nx);
        check_field("norm_y", norm_y, want.ny);
        check_field("norm_z", norm_z, want.nz);
        check_field("tex_s", tex_s, want.ts);
        check_field("tex_t", tex_t, want.tt);
        check_field("vertex_number", vertex_number, want.vnum);
        check_field("upper_tri_valid", upper_tri_valid, want.up);
        check_field("lower_tri_valid", lower_tri_valid, want.lo);
        check_field("index_error", index_error, want.err);
      end
    end
  end

  initial begin
    grid_row_t directed [] = '{
      '{0, 0, 0}, '{18, 36, 0}, '{17, 35, 0}, '{0, 36, 0}, '{18, 0, 0},
      '{9, 18, 0}, '{1, 1, 0}, '{17, 0, 0}, '{0, 35, 0}, '{4, 9, 0},
      '{19, 0, 1}, '{0, 37, 1}, '{255, 511, 1}, '{128, 256, 1}, '{19, 37, 1}
    };
    phase_t phases [] = '{
      '{256, 36, 18, 150, 0, 0},   '{0, 3, 2, 120, 0, 0},
      '{65535, 256, 128, 220, 0, 1}, '{1000, 0, 0, 120, 1, 0},
      '{300, 511, 255, 200, 0, 0}, '{12345, 100, 77, 200, 0, 0},
      '{256, 7, 1, 120, 0, 0},     '{0, 0, 0, 250, 0, 0}
    };
    phase_t ph;
    longint ns, nt;
    int unsigned i, j;

    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    item_valid = 1'b0; stack_index = '0; sector_index = '0;
    calm = 1'b0;
    radius_q = RADIUS_RESET; sectors_q = SECTORS_RESET; stacks_q = STACKS_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed grid points under the reset registers
    foreach (directed[n]) send_point(directed[n].i, directed[n].j, directed[n].is_error);
    drain();

    foreach (phases[p]) begin
      ph = phases[p];
      // last phase takes fully random registers
      if (p == phases.size() - 1) begin
        ph.radius = $urandom_range(65535);
        ph.sectors = $urandom_range(511);
        ph.stacks = $urandom_range(255);
      end
      write_reg(REG_RADIUS, ph.radius);
      write_reg(REG_SECTORS, ph.sectors);
      write_reg(REG_STACKS, ph.stacks);
      calm = ph.calm;
      ns = (sectors_q < 3) ? 3 : (sectors_q > 256) ? 256 : sectors_q;
      nt = (stacks_q < 2) ? 2 : (stacks_q > 128) ? 128 : stacks_q;
      if (ph.hold) hold_asked++;
      // corners of the grid and one row past it first
      send_point(0, 0, 0);
      send_point(32'(nt), 32'(ns), 0);
      send_point(32'(nt - 1), 32'(ns - 1), 0);
      send_point(32'(nt + 1), 0, 0);
      for (int n = 0; n < ph.count; n++) begin
        if ($urandom_range(99) < 85) begin
          i = $urandom_range(32'(nt));
          j = $urandom_range(32'(ns));
        end else begin
          i = $urandom_range(255);
          j = $urandom_range(511);
        end
        send_point(i, j, 0);
      end
      drain();
      calm = 1'b0;
    end

    if (fail_count == 0) begin
      $display("uv_sphere_vertex_generator_tb passed");
    end else begin
      $display("uv_sphere_vertex_generator_tb failed");
    end
    $finish;
  end

endmodule
